>>> hw/rtl/assert_macros.svh
// assertion helpers used by mats_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/mats_pkg.sv
package mats_pkg;

  localparam int ADDR_W      = 20;
  localparam int COUNT_W     = 16;
  localparam int BYTE_W      = 8;
  localparam int STAGE_W     = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 20;

  localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;

  // march stages, A through F
  localparam logic [STAGE_W-1:0] STAGE_A = 3'd0;
  localparam logic [STAGE_W-1:0] STAGE_B = 3'd1;
  localparam logic [STAGE_W-1:0] STAGE_C = 3'd2;
  localparam logic [STAGE_W-1:0] STAGE_D = 3'd3;
  localparam logic [STAGE_W-1:0] STAGE_E = 3'd4;
  localparam logic [STAGE_W-1:0] STAGE_F = 3'd5;

  localparam logic OP_START = 1'b0;
  localparam logic OP_VISIT = 1'b1;

  localparam logic ALG_MATS      = 1'b0;
  localparam logic ALG_MATS_PLUS = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LAST  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALG   = 2'd2;

  typedef enum logic [1:0] {
    CHK_NONE,
    CHK_ZERO,
    CHK_ONES
  } check_t;

  typedef struct packed {
    logic              en;
    logic [BYTE_W-1:0] value;
  } write_op_t;

  typedef struct packed {
    logic               opcode;
    logic [BYTE_W-1:0]  read_byte;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  visit_address;
    logic               write_enable;
    logic [BYTE_W-1:0]  write_byte;
    logic               fault_found;
    logic               stuck_value;
    logic [STAGE_W-1:0] stage_number;
    logic [BYTE_W-1:0]  observed_byte;
    logic [COUNT_W-1:0] fault_total;
    logic [ADDR_W-1:0]  next_address;
    logic               next_needs_read;
    logic               test_done;
  } rsp_t;

  typedef struct packed {
    logic               finished;
    logic [STAGE_W-1:0] stage;
  } seq_status_t;

  // read check of a stage
  function automatic check_t check_kind(input logic sel, input logic [STAGE_W-1:0] stage);
    check_t c;
    c = CHK_NONE;
    if (sel == ALG_MATS) begin
      case (stage)
        STAGE_B: c = CHK_ZERO;
        STAGE_C: c = CHK_ONES;
        default: c = CHK_NONE;
      endcase
    end else begin
      case (stage)
        STAGE_C, STAGE_F: c = CHK_ZERO;
        STAGE_D, STAGE_E: c = CHK_ONES;
        default:          c = CHK_NONE;
      endcase
    end
    return c;
  endfunction

  // write done at a visit of a stage
  function automatic write_op_t write_op(input logic sel, input logic [STAGE_W-1:0] stage);
    write_op_t w;
    w = '0;
    case (stage)
      STAGE_A: w = '{en: 1'b1, value: BYTE_ZERO};
      STAGE_B: w = '{en: 1'b1, value: BYTE_ONES};
      STAGE_C: if (sel == ALG_MATS_PLUS) w = '{en: 1'b1, value: BYTE_ONES};
      STAGE_D: if (sel == ALG_MATS_PLUS) w = '{en: 1'b1, value: BYTE_ZERO};
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/march_memory_test_sequencer.sv
// channel   direction  handshake                payload
// cmd       in         cmd_valid / cmd_ready    mats_pkg::cmd_t (opcode, read_byte)
// rsp       out        rsp_valid / rsp_ready    mats_pkg::rsp_t (visit and next-cell info)
// cfg       in         cfg_we, no wait          cfg_index, cfg_data
//
// a command is taken, the sequencer state updates and the result lands in the
// output register at the same edge
// sustained rate is one beat per clock while rsp_ready stays high, set by the single state update per visit
// cmd_ready is high while the output register is empty or being emptied
// rst is synchronous: settings clear to 0, the sequencer comes up finished
// a stalled rsp holds its beat and only stops new commands, not configuration
module march_memory_test_sequencer #(
  parameter int ADDR_BITS  = 20,
  parameter int COUNT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  mats_pkg::cmd_t                      cmd,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output mats_pkg::rsp_t                      rsp,
  input  logic                                cfg_we,
  input  logic [mats_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mats_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // settings, kept at their written width
  logic [mats_pkg::ADDR_W-1:0] first_address;
  logic [mats_pkg::ADDR_W-1:0] last_address;
  logic                        algorithm_select;

  // walk state
  mats_pkg::seq_status_t       status;
  mats_pkg::seq_status_t       status_next;
  logic [ADDR_BITS-1:0]        current_address;
  logic [ADDR_BITS-1:0]        current_address_next;
  logic [COUNT_BITS-1:0]       fault_counter;
  logic [COUNT_BITS-1:0]       fault_counter_next;
  mats_pkg::rsp_t              rsp_next;

  // settings as seen at the configured address width
  logic [ADDR_BITS+mats_pkg::ADDR_W-1:0] first_ext;
  logic [ADDR_BITS+mats_pkg::ADDR_W-1:0] last_ext;
  logic                                  accept;

  assign first_ext = {{ADDR_BITS{1'b0}}, first_address};
  assign last_ext  = {{ADDR_BITS{1'b0}}, last_address};

  // output register frees up in the same cycle it is drained
  assign cmd_ready = !rsp_valid || rsp_ready;
  assign accept    = cmd_valid && cmd_ready;

  mats_step #(
    .ADDR_BITS  (ADDR_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .alg         (algorithm_select),
    .f_addr      (first_ext[ADDR_BITS-1:0]),
    .l_addr      (last_ext[ADDR_BITS-1:0]),
    .status      (status),
    .addr        (current_address),
    .count       (fault_counter),
    .cmd         (cmd),
    .status_next (status_next),
    .addr_next   (current_address_next),
    .count_next  (fault_counter_next),
    .rsp         (rsp_next)
  );

  // configuration writes, taken whenever enabled
  always_ff @(posedge clk) begin
    if (rst) begin
      first_address    <= '0;
      last_address     <= '0;
      algorithm_select <= mats_pkg::ALG_MATS;
    end else if (cfg_we) begin
      case (cfg_index)
        mats_pkg::CFG_FIRST: first_address    <= cfg_data;
        mats_pkg::CFG_LAST:  last_address     <= cfg_data;
        mats_pkg::CFG_ALG:   algorithm_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // walk state advances once per accepted command
  always_ff @(posedge clk) begin
    if (rst) begin
      status.finished <= 1'b1;
      status.stage    <= mats_pkg::STAGE_A;
      current_address <= '0;
      fault_counter   <= '0;
    end else if (accept) begin
      status          <= status_next;
      current_address <= current_address_next;
      fault_counter   <= fault_counter_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

>>> hw/rtl/mats_step.sv
module mats_step #(
  parameter int ADDR_BITS  = 20,
  parameter int COUNT_BITS = 16
) (
  input  logic                        alg,
  input  logic [ADDR_BITS-1:0]        f_addr,
  input  logic [ADDR_BITS-1:0]        l_addr,
  input  mats_pkg::seq_status_t       status,
  input  logic [ADDR_BITS-1:0]        addr,
  input  logic [COUNT_BITS-1:0]       count,
  input  mats_pkg::cmd_t              cmd,
  output mats_pkg::seq_status_t       status_next,
  output logic [ADDR_BITS-1:0]        addr_next,
  output logic [COUNT_BITS-1:0]       count_next,
  output mats_pkg::rsp_t              rsp
);

  localparam int STAGE_SLOTS = 2 ** mats_pkg::STAGE_W;

  typedef struct packed {
    logic                 ok;
    logic [ADDR_BITS-1:0] lo;
    logic [ADDR_BITS-1:0] hi;
  } range_t;

  // cell range of one stage under the current settings
  function automatic range_t stage_range(input logic [mats_pkg::STAGE_W-1:0] s,
                                         input logic sel,
                                         input logic [ADDR_BITS-1:0] f,
                                         input logic [ADDR_BITS-1:0] l);
    range_t r;
    r.ok = 1'b0;
    r.lo = f;
    r.hi = l;
    if (l >= f) begin
      if (sel == mats_pkg::ALG_MATS) begin
        r.ok = (s <= mats_pkg::STAGE_C);
      end else begin
        case (s)
          mats_pkg::STAGE_A, mats_pkg::STAGE_C: begin
            r.ok = (f != l);
            r.lo = f + ADDR_BITS'(1);
          end
          mats_pkg::STAGE_B, mats_pkg::STAGE_F: begin
            r.ok = 1'b1;
            r.hi = f;
          end
          mats_pkg::STAGE_D: begin
            r.ok = 1'b1;
            r.hi = (f == l) ? f : l - ADDR_BITS'(1);
          end
          mats_pkg::STAGE_E: begin
            r.ok = (f != l);
            r.lo = l;
          end
          default: r.ok = 1'b0;
        endcase
      end
    end
    return r;
  endfunction

  range_t                          rng [STAGE_SLOTS];
  range_t                          cur_rng;
  logic [mats_pkg::STAGE_W-1:0]    search_from;
  logic                            found;
  logic [mats_pkg::STAGE_W-1:0]    ent_stage;
  logic [ADDR_BITS-1:0]            ent_addr;
  mats_pkg::check_t                chk;
  mats_pkg::write_op_t             wop;
  logic                            mismatch;
  logic [ADDR_BITS+mats_pkg::ADDR_W-1:0]   vis_ext;
  logic [ADDR_BITS+mats_pkg::ADDR_W-1:0]   nxt_ext;
  logic [COUNT_BITS+mats_pkg::COUNT_W-1:0] cnt_ext;

  always_comb begin
    for (int i = 0; i < STAGE_SLOTS; i++) begin
      rng[i] = stage_range(mats_pkg::STAGE_W'(i), alg, f_addr, l_addr);
    end
  end

  assign cur_rng = rng[status.stage];

  // start walks from stage A, a finished stage from the one after it
  assign search_from = (cmd.opcode == mats_pkg::OP_START) ? mats_pkg::STAGE_A
                                                          : status.stage + 3'd1;

  // first non-empty stage at or after search_from
  always_comb begin
    found     = 1'b0;
    ent_stage = mats_pkg::STAGE_A;
    ent_addr  = '0;
    for (int i = 0; i < STAGE_SLOTS; i++) begin
      if (!found && (mats_pkg::STAGE_W'(i) >= search_from) && rng[i].ok) begin
        found     = 1'b1;
        ent_stage = mats_pkg::STAGE_W'(i);
        ent_addr  = rng[i].lo;
      end
    end
  end

  assign chk      = mats_pkg::check_kind(alg, status.stage);
  assign wop      = mats_pkg::write_op(alg, status.stage);
  assign mismatch = ((chk == mats_pkg::CHK_ZERO) && (cmd.read_byte != mats_pkg::BYTE_ZERO)) ||
                    ((chk == mats_pkg::CHK_ONES) && (cmd.read_byte != mats_pkg::BYTE_ONES));

  assign vis_ext = {{mats_pkg::ADDR_W{1'b0}}, addr};

  always_comb begin
    status_next = status;
    addr_next   = addr;
    count_next  = count;
    rsp         = '0;
    if (cmd.opcode == mats_pkg::OP_START) begin
      count_next           = '0;
      status_next.finished = !found;
      status_next.stage    = found ? ent_stage : mats_pkg::STAGE_A;
      addr_next            = found ? ent_addr : '0;
    end else if (!status.finished) begin
      rsp.visit_address = vis_ext[mats_pkg::ADDR_W-1:0];
      rsp.write_enable  = wop.en;
      rsp.write_byte    = wop.value;
      rsp.stage_number  = status.stage;
      if (mismatch) begin
        rsp.fault_found   = 1'b1;
        rsp.stuck_value   = (chk == mats_pkg::CHK_ZERO);
        rsp.observed_byte = cmd.read_byte;
        if (count != '1) begin
          count_next = count + COUNT_BITS'(1);
        end
      end
      if (cur_rng.ok && (addr < cur_rng.hi)) begin
        addr_next = addr + ADDR_BITS'(1);
      end else if (found) begin
        status_next.stage = ent_stage;
        addr_next         = ent_addr;
      end else begin
        status_next.finished = 1'b1;
      end
    end
    nxt_ext = {{mats_pkg::ADDR_W{1'b0}}, addr_next};
    cnt_ext = {{mats_pkg::COUNT_W{1'b0}}, count_next};
    rsp.fault_total = cnt_ext[mats_pkg::COUNT_W-1:0];
    if (status_next.finished) begin
      rsp.test_done = 1'b1;
    end else begin
      rsp.next_address    = nxt_ext[mats_pkg::ADDR_W-1:0];
      rsp.next_needs_read = (mats_pkg::check_kind(alg, status_next.stage) != mats_pkg::CHK_NONE);
    end
  end

endmodule

>>> hw/rtl/mats_checker.sv
`include "assert_macros.svh"

module mats_checker (
  input logic           clk,
  input logic           rst,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input mats_pkg::rsp_t rsp
);

  // a held beat keeps its payload
  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

  // finished walk names no next cell
  `ASSERT_SAME(a_done_quiet, clk, rst, rsp_valid && rsp.test_done,
               rsp.next_address == '0 && !rsp.next_needs_read)

  // fault detail only with a fault
  `ASSERT_SAME(a_fault_detail, clk, rst, rsp_valid && !rsp.fault_found,
               !rsp.stuck_value && rsp.observed_byte == '0)

  // no write data without a write, and stages stay within A..F
  `ASSERT_SAME(a_write_stage, clk, rst, rsp_valid,
               (rsp.write_enable || rsp.write_byte == '0) &&
               rsp.stage_number <= mats_pkg::STAGE_F)

endmodule

bind march_memory_test_sequencer mats_checker u_mats_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

>>> dv/tb_top.sv
module tb_top;

  // run length guard, far above the slowest clean run
  localparam int CYCLE_LIMIT = 100000;
  // receiver hold-off used to back up the sequencer
  localparam int LONG_HOLD = 300;
  // beats per random phase, eight phases in all
  localparam int PHASE_BEATS = 110;
  // top cell once the range is widened mid-walk
  localparam logic [mats_pkg::ADDR_W-1:0] WIDE_LAST = 20'd31;

  typedef struct {
    mats_pkg::cmd_t beat;
    bit             drain_first;
  } queued_beat_t;

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             cmd_valid = 1'b0;
  logic                             cmd_ready;
  mats_pkg::cmd_t                   cmd = '0;
  logic                             rsp_valid;
  logic                             rsp_ready = 1'b0;
  mats_pkg::rsp_t                   rsp;
  logic                             cfg_we = 1'b0;
  logic [mats_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [mats_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // march state as the sequencer should hold it, reset values included
  logic [mats_pkg::STAGE_W-1:0] cur_stage = mats_pkg::STAGE_A;
  logic [mats_pkg::ADDR_W-1:0]  cur_addr = '0;
  logic [mats_pkg::COUNT_W-1:0] fault_tally = '0;
  logic                         walk_done = 1'b1;
  logic [mats_pkg::ADDR_W-1:0]  set_first = '0;
  logic [mats_pkg::ADDR_W-1:0]  set_last = '0;
  logic                         set_alg = mats_pkg::ALG_MATS;

  queued_beat_t   beats_pending[$];
  mats_pkg::rsp_t march_rsp_due[$];
  int             beats_taken = 0;
  int             results_seen = 0;
  int             miscompares = 0;
  int             cycle_count = 0;

  // idling knobs, in percent of cycles
  int send_idle_pct = 0;
  int rsp_stall_pct = 0;
  // long receiver hold-off requests, counted off in the receiver process
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  march_memory_test_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // cell range of a stage under the current settings; 0 when the stage is empty
  function automatic bit span_of(input logic [mats_pkg::STAGE_W-1:0] s,
                                 output logic [mats_pkg::ADDR_W-1:0] lo,
                                 output logic [mats_pkg::ADDR_W-1:0] hi);
    lo = '0;
    hi = '0;
    if (set_last < set_first) return 1'b0;
    if (set_alg == mats_pkg::ALG_MATS) begin
      if (s > mats_pkg::STAGE_C) return 1'b0;
      lo = set_first;
      hi = set_last;
      return 1'b1;
    end
    case (s)
      mats_pkg::STAGE_A, mats_pkg::STAGE_C: begin
        if (set_first == set_last) return 1'b0;
        lo = set_first + mats_pkg::ADDR_W'(1);
        hi = set_last;
      end
      mats_pkg::STAGE_B, mats_pkg::STAGE_F: begin
        lo = set_first;
        hi = set_first;
      end
      mats_pkg::STAGE_D: begin
        // single cell range still gets one pass here
        lo = set_first;
        hi = (set_first == set_last) ? set_first : set_last - mats_pkg::ADDR_W'(1);
      end
      mats_pkg::STAGE_E: begin
        if (set_first == set_last) return 1'b0;
        lo = set_last;
        hi = set_last;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // value a stage expects to read back
  function automatic mats_pkg::check_t read_check(input logic alg,
                                                  input logic [mats_pkg::STAGE_W-1:0] s);
    if (alg == mats_pkg::ALG_MATS) begin
      if (s == mats_pkg::STAGE_B) return mats_pkg::CHK_ZERO;
      if (s == mats_pkg::STAGE_C) return mats_pkg::CHK_ONES;
      return mats_pkg::CHK_NONE;
    end
    case (s)
      mats_pkg::STAGE_C, mats_pkg::STAGE_F: return mats_pkg::CHK_ZERO;
      mats_pkg::STAGE_D, mats_pkg::STAGE_E: return mats_pkg::CHK_ONES;
      default:                              return mats_pkg::CHK_NONE;
    endcase
  endfunction

  // {enable, byte} written at a visit
  function automatic logic [mats_pkg::BYTE_W:0] cell_write(
      input logic alg, input logic [mats_pkg::STAGE_W-1:0] s);
    if (s == mats_pkg::STAGE_A) return {1'b1, mats_pkg::BYTE_ZERO};
    if (s == mats_pkg::STAGE_B) return {1'b1, mats_pkg::BYTE_ONES};
    if (alg == mats_pkg::ALG_MATS_PLUS && s == mats_pkg::STAGE_C)
      return {1'b1, mats_pkg::BYTE_ONES};
    if (alg == mats_pkg::ALG_MATS_PLUS && s == mats_pkg::STAGE_D)
      return {1'b1, mats_pkg::BYTE_ZERO};
    return {1'b0, mats_pkg::BYTE_ZERO};
  endfunction

  // jump to the first cell of the first non-empty stage from 'from' on
  function automatic bit seek_stage(input int from);
    logic [mats_pkg::ADDR_W-1:0] lo, hi;
    for (int s = from; s <= int'(mats_pkg::STAGE_F); s++) begin
      if (span_of(mats_pkg::STAGE_W'(s), lo, hi)) begin
        cur_stage = mats_pkg::STAGE_W'(s);
        cur_addr = lo;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // expected result of one accepted command; updates the march state
  function automatic mats_pkg::rsp_t advance_march(input mats_pkg::cmd_t c);
    mats_pkg::rsp_t              r;
    mats_pkg::check_t            chk;
    logic [mats_pkg::BYTE_W:0]   wr;
    logic [mats_pkg::ADDR_W-1:0] lo, hi;
    r = '0;
    if (c.opcode == mats_pkg::OP_START) begin
      fault_tally = '0;
      cur_stage = mats_pkg::STAGE_A;
      cur_addr = '0;
      walk_done = !seek_stage(int'(mats_pkg::STAGE_A));
    end else if (!walk_done) begin
      chk = read_check(set_alg, cur_stage);
      wr = cell_write(set_alg, cur_stage);
      r.visit_address = cur_addr;
      r.write_enable = wr[mats_pkg::BYTE_W];
      r.write_byte = wr[mats_pkg::BYTE_W-1:0];
      r.stage_number = cur_stage;
      if ((chk == mats_pkg::CHK_ZERO && c.read_byte != mats_pkg::BYTE_ZERO) ||
          (chk == mats_pkg::CHK_ONES && c.read_byte != mats_pkg::BYTE_ONES)) begin
        r.fault_found = 1'b1;
        r.stuck_value = (chk == mats_pkg::CHK_ZERO);
        r.observed_byte = c.read_byte;
        if (fault_tally != '1) fault_tally = fault_tally + mats_pkg::COUNT_W'(1);
      end
      if (span_of(cur_stage, lo, hi) && cur_addr < hi)
        cur_addr = cur_addr + mats_pkg::ADDR_W'(1);
      else if (!seek_stage(int'(cur_stage) + 1)) walk_done = 1'b1;
    end
    // visits after the end leave the state alone
    r.fault_total = fault_tally;
    r.test_done = walk_done;
    if (!walk_done) begin
      r.next_address = cur_addr;
      r.next_needs_read = (read_check(set_alg, cur_stage) != mats_pkg::CHK_NONE);
    end
    return r;
  endfunction

  // driver: offers queued beats, predicts each one at acceptance
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        march_rsp_due.push_back(advance_march(cmd));
        beats_taken <= beats_taken + 1;
      end
      if (!cmd_valid || cmd_ready) begin
        // a beat marked drain_first waits until every owed result is back
        if (beats_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
            !(beats_pending[0].drain_first &&
              (cmd_valid || beats_taken != results_seen))) begin
          cmd <= beats_pending[0].beat;
          beats_pending.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus the occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_asks) begin
      rsp_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_seen <= hold_asks;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      miscompares++;
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
    end
  endtask

  // monitor: each result beat against the oldest owed result
  always @(posedge clk) begin
    mats_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      // counters hold last-edge values, so this does not race the driver's push
      if (beats_taken == results_seen) begin
        miscompares++;
        $error("result beat with nothing owed: 'h%0h", rsp);
      end else begin
        want = march_rsp_due.pop_front();
        results_seen <= results_seen + 1;
        compare_field("visit_address", 32'(want.visit_address), 32'(rsp.visit_address));
        compare_field("write_enable", 32'(want.write_enable), 32'(rsp.write_enable));
        compare_field("write_byte", 32'(want.write_byte), 32'(rsp.write_byte));
        compare_field("fault_found", 32'(want.fault_found), 32'(rsp.fault_found));
        compare_field("stuck_value", 32'(want.stuck_value), 32'(rsp.stuck_value));
        compare_field("stage_number", 32'(want.stage_number), 32'(rsp.stage_number));
        compare_field("observed_byte", 32'(want.observed_byte), 32'(rsp.observed_byte));
        compare_field("fault_total", 32'(want.fault_total), 32'(rsp.fault_total));
        compare_field("next_address", 32'(want.next_address), 32'(rsp.next_address));
        compare_field("next_needs_read", 32'(want.next_needs_read),
                      32'(rsp.next_needs_read));
        compare_field("test_done", 32'(want.test_done), 32'(rsp.test_done));
      end
    end
  end

  function automatic void queue_beat(input logic op,
                                     input logic [mats_pkg::BYTE_W-1:0] data,
                                     input bit drain = 1'b0);
    queued_beat_t q;
    q.beat.opcode = op;
    q.beat.read_byte = data;
    q.drain_first = drain;
    beats_pending.push_back(q);
  endfunction

  // read data mostly matching one of the two patterns, sometimes off by a bit or fully random
  function automatic logic [mats_pkg::BYTE_W-1:0] visit_byte();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return mats_pkg::BYTE_ZERO;
    if (pick < 8) return mats_pkg::BYTE_ONES;
    if (pick == 8)
      return (($urandom_range(0, 1) != 0) ? mats_pkg::BYTE_ONES : mats_pkg::BYTE_ZERO) ^
             (8'h01 << $urandom_range(0, 7));
    return mats_pkg::BYTE_W'($urandom_range(0, 255));
  endfunction

  // wait at negedges until no beat is queued, offered or owed
  task automatic settle();
    @(negedge clk);
    while (beats_pending.size() != 0 || cmd_valid || beats_taken != results_seen)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // one register write, only ever issued while the sequencer is idle
  task automatic write_reg(input logic [mats_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [mats_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      mats_pkg::CFG_FIRST: set_first = val;
      mats_pkg::CFG_LAST:  set_last = val;
      mats_pkg::CFG_ALG:   set_alg = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_range(input logic [mats_pkg::ADDR_W-1:0] lo,
                           input logic [mats_pkg::ADDR_W-1:0] hi,
                           input logic alg);
    write_reg(mats_pkg::CFG_FIRST, lo);
    write_reg(mats_pkg::CFG_LAST, hi);
    write_reg(mats_pkg::CFG_ALG, mats_pkg::CFG_DATA_W'(alg));
  endtask

  // random settings, then mostly complete walks with some broken ones and noise
  task automatic random_phase(input int ph);
    logic [mats_pkg::ADDR_W-1:0] lo_cfg, hi_cfg;
    int                          kind, walk, made, pick, cut;
    bit                          paused, drain;
    settle();
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin
        // last below first: nothing to walk
        lo_cfg = mats_pkg::ADDR_W'($urandom_range(1, 20'hFFFFF));
        hi_cfg = mats_pkg::ADDR_W'($urandom_range(0, lo_cfg - 1));
      end
      1: begin
        lo_cfg = mats_pkg::ADDR_W'($urandom_range(0, 20'hFFFFF));
        hi_cfg = lo_cfg;
      end
      2: begin
        hi_cfg = 20'hFFFFF;
        lo_cfg = mats_pkg::ADDR_W'(hi_cfg - $urandom_range(0, 5));
      end
      3: begin
        lo_cfg = '0;
        hi_cfg = mats_pkg::ADDR_W'($urandom_range(0, 5));
      end
      default: begin
        lo_cfg = mats_pkg::ADDR_W'($urandom_range(0, 20'hFFFFF - 8));
        hi_cfg = mats_pkg::ADDR_W'(lo_cfg + $urandom_range(1, 7));
      end
    endcase
    set_range(lo_cfg, hi_cfg, 1'($urandom_range(0, 1)));
    // three visits per cell whichever algorithm is selected
    walk = (hi_cfg < lo_cfg) ? 0 : 3 * (int'(hi_cfg - lo_cfg) + 1);

    case (ph % 4)
      0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
      1: begin send_idle_pct = 80; rsp_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  rsp_stall_pct = 80; end
      default: begin send_idle_pct = 12; rsp_stall_pct = 12; end
    endcase
    // receiver goes dark while the sender keeps pushing, so the block backs up
    if (ph == 4) hold_asks++;

    made = 0;
    paused = 1'b0;
    while (made < PHASE_BEATS) begin
      pick = $urandom_range(0, 19);
      if (pick < 18) begin
        // one sender pause per phase, halfway in
        drain = !paused && made >= PHASE_BEATS / 2;
        if (drain) paused = 1'b1;
        queue_beat(mats_pkg::OP_START, mats_pkg::BYTE_W'($urandom_range(0, 255)), drain);
        made++;
        cut = (pick < 16) ? walk : $urandom_range(0, walk);
        for (int k = 0; k < cut; k++) queue_beat(mats_pkg::OP_VISIT, visit_byte());
        made += cut;
        // a stray visit past the end now and then
        if (pick < 16 && $urandom_range(0, 3) == 0)
          queue_beat(mats_pkg::OP_VISIT, visit_byte());
      end else begin
        repeat ($urandom_range(1, 4)) begin
          queue_beat(($urandom_range(0, 1) != 0) ? mats_pkg::OP_VISIT : mats_pkg::OP_START,
                     mats_pkg::BYTE_W'($urandom_range(0, 255)));
          made++;
        end
      end
    end
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: one cell at address 0, MATS; visit before any start is ignored
    queue_beat(mats_pkg::OP_VISIT, 8'h5A);
    queue_beat(mats_pkg::OP_START, mats_pkg::BYTE_ZERO);
    queue_beat(mats_pkg::OP_VISIT, mats_pkg::BYTE_ZERO);
    queue_beat(mats_pkg::OP_VISIT, mats_pkg::BYTE_ZERO);
    queue_beat(mats_pkg::OP_VISIT, mats_pkg::BYTE_ONES);
    queue_beat(mats_pkg::OP_VISIT, 8'hC3);

    // top of the address space, MATS+, faults of both kinds
    settle();
    set_range(20'hFFFFE, 20'hFFFFF, mats_pkg::ALG_MATS_PLUS);
    queue_beat(mats_pkg::OP_START, mats_pkg::BYTE_ONES);
    queue_beat(mats_pkg::OP_VISIT, mats_pkg::BYTE_ZERO);
    queue_beat(mats_pkg::OP_VISIT, mats_pkg::BYTE_ONES);
    queue_beat(mats_pkg::OP_VISIT, 8'h01);   // stuck at 1
    queue_beat(mats_pkg::OP_VISIT, 8'h7F);   // stuck at 0
    queue_beat(mats_pkg::OP_VISIT, mats_pkg::BYTE_ONES);
    queue_beat(mats_pkg::OP_VISIT, 8'h80);   // stuck at 1 in the final stage

    // single cell under MATS+: B, one D pass, then F
    settle();
    set_range(20'd7, 20'd7, mats_pkg::ALG_MATS_PLUS);
    queue_beat(mats_pkg::OP_START, mats_pkg::BYTE_ZERO);
    queue_beat(mats_pkg::OP_VISIT, mats_pkg::BYTE_ONES);
    queue_beat(mats_pkg::OP_VISIT, mats_pkg::BYTE_ONES);
    queue_beat(mats_pkg::OP_VISIT, mats_pkg::BYTE_ZERO);

    // last below first: start ends the test at once
    settle();
    set_range(20'd9, 20'd4, mats_pkg::ALG_MATS_PLUS);
    queue_beat(mats_pkg::OP_START, mats_pkg::BYTE_ZERO);
    queue_beat(mats_pkg::OP_VISIT, mats_pkg::BYTE_ZERO);

    // whole address space; only the first cells, the walk is left open
    settle();
    set_range(20'h00000, 20'hFFFFF, mats_pkg::ALG_MATS);
    queue_beat(mats_pkg::OP_START, mats_pkg::BYTE_ZERO);
    queue_beat(mats_pkg::OP_VISIT, mats_pkg::BYTE_ONES);
    queue_beat(mats_pkg::OP_VISIT, mats_pkg::BYTE_ZERO);

    for (int ph = 0; ph < 8; ph++) random_phase(ph);

    // park a walk in stage B at cell 0, then widen the range mid-walk
    settle();
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    set_range('0, '0, mats_pkg::ALG_MATS);
    queue_beat(mats_pkg::OP_START, mats_pkg::BYTE_ZERO);
    queue_beat(mats_pkg::OP_VISIT, mats_pkg::BYTE_ZERO);
    settle();
    write_reg(mats_pkg::CFG_LAST, WIDE_LAST);
    // every read is wrong for both expected patterns
    for (int k = 0; k < 2 * (int'(WIDE_LAST) + 1); k++)
      queue_beat(mats_pkg::OP_VISIT, mats_pkg::BYTE_W'($urandom_range(1, 254)));
    queue_beat(mats_pkg::OP_VISIT, mats_pkg::BYTE_ZERO);
    // fresh start clears the count
    queue_beat(mats_pkg::OP_START, mats_pkg::BYTE_ZERO);

    settle();
    // trailing window for stray result beats
    repeat (20) @(negedge clk);
    if (miscompares == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

>>> march_memory_test_sequencer.f
+incdir+hw/rtl
hw/rtl/mats_pkg.sv
hw/rtl/mats_step.sv
hw/rtl/march_memory_test_sequencer.sv
hw/rtl/mats_checker.sv
dv/tb_top.sv
